### rtl/core/lz4fd_pkg.sv
// ----------------------------------------------------------------------------
// lz4fd_pkg
// Shared types and constants for the LZ4 frame decompressor.
// ----------------------------------------------------------------------------
package lz4fd_pkg;

  localparam int unsigned WINDOW_BYTES_DEF = 65536;
  localparam logic [31:0] FRAME_MAGIC      = 32'h184D2204;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_END     = 3'd1,
    KIND_BAD_MAG = 3'd2,
    KIND_BAD_OFS = 3'd3,
    KIND_REFUSED = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_FLG, PH_HDR, PH_BSIZE, PH_STORED, PH_TOKEN, PH_LITEXT,
    PH_LITERAL, PH_OFFSET, PH_MATCHEXT, PH_COPY, PH_CKSUM, PH_DONE, PH_DEAD
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  kind;
    logic [31:0] total_length;
    logic        copy_pending;
  } out_word_t;

  // Parser to history memory: one write request and one read request.
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_data;
    logic       rd_en;
  } hist_req_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### rtl/core/lz4fd_history.sv
// ----------------------------------------------------------------------------
// lz4fd_history
// History window memory with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lz4fd_history
  import lz4fd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF,
  localparam int unsigned AW = $clog2(WINDOW_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hist_req_t     req,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic [AW-1:0] wr_pos
);

  logic [7:0]    mem [WINDOW_BYTES];
  logic [AW-1:0] wr_pos_r;
  logic [AW-1:0] wr_pos_nxt;

  // wrap at the window size, which need not be a power of two
  assign wr_pos_nxt = (wr_pos_r == AW'(WINDOW_BYTES - 1)) ? '0 : wr_pos_r + AW'(1);
  assign wr_pos     = wr_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
    end else if (req.wr_en) begin
      wr_pos_r <= wr_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_pos_r] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/lz4_frame_decompressor.sv
// ----------------------------------------------------------------------------
// lz4_frame_decompressor
// LZ4 frame parser with a history window for match copies.
// ----------------------------------------------------------------------------
// Latency: a stream byte's result is registered and shown the next cycle.
// A drain tick reads the history into the drain stage, then the output register.
// Throughput: one word per cycle while the output is not stalled, except that
// the input also stalls after each drain tick while the history read completes.
// Reset: synchronous, active low; history contents are undefined and never
// read before being written.
module lz4_frame_decompressor
  import lz4fd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF,
  localparam int unsigned AW = $clog2(WINDOW_BYTES)
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  phase_t      ph_r, ph_nxt;
  logic [3:0]  fbc_r, fbc_nxt;
  logic [3:0]  hsk_r, hsk_nxt;
  logic [31:0] sacc_r, sacc_nxt;
  logic [30:0] bbl_r, bbl_nxt;
  logic        cks_r, cks_nxt;
  logic [3:0]  tln_r, tln_nxt;
  logic [31:0] lit_r, lit_nxt;
  logic [15:0] mofs_r, mofs_nxt;
  logic [31:0] mlen_r, mlen_nxt;
  logic [31:0] bout_r, bout_nxt;

  // Drain stage: history read in flight.
  logic        d_vld_r;
  logic [31:0] d_tot_r;
  logic        d_cp_r;
  logic        d_fwd_r;
  logic [7:0]  d_fwd_byte_r;

  // Output register.
  logic        o_vld_r;
  out_word_t   o_r;

  logic        acc, emit;
  out_word_t   ew;
  logic        drain;
  hist_req_t   hreq;
  logic [AW-1:0] rd_addr, wr_pos, ofs_a;
  logic [7:0]  rd_data, d_byte;
  logic        st_wr;
  logic [7:0]  st_byte;
  logic        out_free;
  logic [7:0]  b;
  logic [31:0] bsize;
  logic [30:0] bbl_dec;

  // Stall when the output is full and would not drain, or a drain result is
  // still in flight and the register would be occupied.
  assign out_free = !o_vld_r || !out_stall;
  assign in_stall = !out_free || d_vld_r;
  assign acc      = in_valid && !in_stall;
  assign b        = in_data.in_byte;
  assign bsize    = sacc_r | (32'(b) << {fbc_r[1:0], 3'b000});
  assign bbl_dec  = (bbl_r != '0) ? bbl_r - 31'd1 : bbl_r;

  assign d_byte   = d_fwd_r ? d_fwd_byte_r : rd_data;
  // step back by the offset, wrapping within the window
  assign ofs_a    = AW'(mofs_r);
  assign rd_addr  = (wr_pos >= ofs_a) ? wr_pos - ofs_a
                                      : wr_pos + AW'(WINDOW_BYTES) - ofs_a;

  always_comb begin
    ph_nxt = ph_r; fbc_nxt = fbc_r; hsk_nxt = hsk_r; sacc_nxt = sacc_r;
    bbl_nxt = bbl_r; cks_nxt = cks_r; tln_nxt = tln_r; lit_nxt = lit_r;
    mofs_nxt = mofs_r; mlen_nxt = mlen_r; bout_nxt = bout_r;
    emit = 1'b0; ew = '0; drain = 1'b0; st_wr = 1'b0; st_byte = b;
    if (acc) begin
      if (in_data.op) begin
        if (ph_r == PH_COPY && mlen_r != '0) begin
          drain    = 1'b1;
          mlen_nxt = mlen_r - 32'd1;
          bout_nxt = sat_add(bout_r, 32'd1);
          if (mlen_nxt == '0) begin
            if (bbl_r == '0) begin
              ph_nxt = cks_r ? PH_CKSUM : PH_BSIZE;
              fbc_nxt = '0; sacc_nxt = '0;
            end else begin
              ph_nxt = PH_TOKEN;
            end
          end
        end
      end else begin
        unique case (ph_r)
          PH_COPY: begin
            emit = 1'b1; ew.kind = KIND_REFUSED;
          end
          PH_MAGIC: begin
            if (b != FRAME_MAGIC[{fbc_r[1:0], 3'b000} +: 8]) begin
              ph_nxt = PH_DEAD; emit = 1'b1; ew.kind = KIND_BAD_MAG;
            end else if (fbc_r == 4'd3) begin
              fbc_nxt = '0; ph_nxt = PH_FLG;
            end else begin
              fbc_nxt = fbc_r + 4'd1;
            end
          end
          PH_FLG: begin
            cks_nxt = b[4];
            hsk_nxt = 4'd2 + (b[3] ? 4'd8 : 4'd0) + (b[0] ? 4'd4 : 4'd0);
            ph_nxt  = PH_HDR;
          end
          PH_HDR: begin
            hsk_nxt = (hsk_r != '0) ? hsk_r - 4'd1 : hsk_r;
            if (hsk_nxt == '0) begin
              ph_nxt = PH_BSIZE; fbc_nxt = '0; sacc_nxt = '0;
            end
          end
          PH_BSIZE: begin
            sacc_nxt = bsize;
            fbc_nxt  = fbc_r + 4'd1;
            if (fbc_r == 4'd3) begin
              fbc_nxt = '0;
              if (bsize == '0) begin
                ph_nxt = PH_DONE; emit = 1'b1; ew.kind = KIND_END;
              end else begin
                bbl_nxt = bsize[30:0];
                if (!bsize[31]) begin
                  ph_nxt = PH_TOKEN;
                end else if (bsize[30:0] == '0) begin
                  ph_nxt = cks_r ? PH_CKSUM : PH_BSIZE; sacc_nxt = '0;
                end else begin
                  ph_nxt = PH_STORED;
                end
              end
            end
          end
          PH_STORED: begin
            bbl_nxt = bbl_dec;
            if (bbl_dec == '0) begin
              ph_nxt = cks_r ? PH_CKSUM : PH_BSIZE; fbc_nxt = '0; sacc_nxt = '0;
            end
            st_wr = 1'b1;
          end
          PH_CKSUM: begin
            fbc_nxt = fbc_r + 4'd1;
            if (fbc_r >= 4'd3) begin
              ph_nxt = PH_BSIZE; fbc_nxt = '0; sacc_nxt = '0;
            end
          end
          PH_TOKEN, PH_LITEXT, PH_LITERAL, PH_OFFSET, PH_MATCHEXT: begin
            bbl_nxt = bbl_dec;
            priority if (ph_r == PH_TOKEN) begin
              tln_nxt = b[3:0];
              lit_nxt = 32'(b[7:4]);
              if (b[7:4] == 4'd15) ph_nxt = PH_LITEXT;
              else if (b[7:4] != '0) ph_nxt = PH_LITERAL;
              else if (bbl_dec == '0) begin
                ph_nxt = cks_r ? PH_CKSUM : PH_BSIZE; fbc_nxt = '0; sacc_nxt = '0;
              end else begin
                ph_nxt = PH_OFFSET; fbc_nxt = '0; mofs_nxt = '0;
              end
            end else if (ph_r == PH_LITEXT) begin
              lit_nxt = sat_add(lit_r, 32'(b));
              if (b != 8'hFF) begin
                if (lit_nxt != '0) ph_nxt = PH_LITERAL;
                else if (bbl_dec == '0) begin
                  ph_nxt = cks_r ? PH_CKSUM : PH_BSIZE; fbc_nxt = '0; sacc_nxt = '0;
                end else begin
                  ph_nxt = PH_OFFSET; fbc_nxt = '0; mofs_nxt = '0;
                end
              end
            end else if (ph_r == PH_LITERAL) begin
              lit_nxt = lit_r - 32'd1;
              st_wr = 1'b1;
              if (lit_nxt == '0) begin
                if (bbl_dec == '0) begin
                  ph_nxt = cks_r ? PH_CKSUM : PH_BSIZE; fbc_nxt = '0; sacc_nxt = '0;
                end else begin
                  ph_nxt = PH_OFFSET; fbc_nxt = '0; mofs_nxt = '0;
                end
              end
            end else begin
              if (ph_r == PH_OFFSET) begin
                mofs_nxt = fbc_r[0] ? {b, mofs_r[7:0]} : {mofs_r[15:8], b};
                fbc_nxt  = fbc_r + 4'd1;
                mlen_nxt = 32'(tln_r) + 32'd4;
              end else begin
                mlen_nxt = sat_add(mlen_r, 32'(b));
              end
              if ((ph_r == PH_OFFSET && fbc_r[0] && tln_r == 4'd15)) begin
                fbc_nxt = '0; ph_nxt = PH_MATCHEXT;
              end else if ((ph_r == PH_OFFSET && fbc_r[0])
                           || (ph_r == PH_MATCHEXT && b != 8'hFF)) begin
                fbc_nxt = '0;
                if (mofs_nxt == '0 || 32'(mofs_nxt) > bout_r
                    || 33'(mofs_nxt) > 33'(WINDOW_BYTES)) begin
                  mlen_nxt = '0; emit = 1'b1; ew.kind = KIND_BAD_OFS;
                  if (bbl_dec == '0) begin
                    ph_nxt = cks_r ? PH_CKSUM : PH_BSIZE; sacc_nxt = '0;
                  end else begin
                    ph_nxt = PH_TOKEN;
                  end
                end else begin
                  ph_nxt = PH_COPY;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
    if (st_wr) begin
      bout_nxt = sat_add(bout_r, 32'd1);
      emit = 1'b1; ew.kind = KIND_DATA; ew.out_byte = st_byte;
    end
    ew.total_length = bout_nxt;
    ew.copy_pending = (mlen_nxt != '0);
  end

  // Stored and literal bytes go in at once; drained bytes when read back.
  always_comb begin
    hreq.rd_en   = drain;
    hreq.wr_en   = st_wr || d_vld_r;
    hreq.wr_data = d_vld_r ? d_byte : st_byte;
  end

  lz4fd_history #(.WINDOW_BYTES(WINDOW_BYTES)) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_pos  (wr_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_MAGIC; fbc_r <= '0; hsk_r <= '0; sacc_r <= '0; bbl_r <= '0;
      cks_r <= 1'b0; tln_r <= '0; lit_r <= '0; mofs_r <= '0; mlen_r <= '0;
      bout_r <= '0; d_vld_r <= 1'b0; o_vld_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; fbc_r <= fbc_nxt; hsk_r <= hsk_nxt; sacc_r <= sacc_nxt;
      bbl_r <= bbl_nxt; cks_r <= cks_nxt; tln_r <= tln_nxt; lit_r <= lit_nxt;
      mofs_r <= mofs_nxt; mlen_r <= mlen_nxt; bout_r <= bout_nxt;
      d_vld_r <= drain;
      if (d_vld_r || emit) o_vld_r <= 1'b1;
      else if (!out_stall) o_vld_r <= 1'b0;
    end
  end

  // Payload registers. A drain reading the entry written this cycle takes
  // the write data instead of the stale memory word.
  always_ff @(posedge clk) begin
    d_tot_r <= bout_nxt;
    d_cp_r  <= (mlen_nxt != '0);
    d_fwd_r <= hreq.wr_en && (rd_addr == wr_pos);
    d_fwd_byte_r <= hreq.wr_data;
    if (d_vld_r) begin
      o_r.out_byte     <= d_byte;
      o_r.kind         <= KIND_DATA;
      o_r.total_length <= d_tot_r;
      o_r.copy_pending <= d_cp_r;
    end else if (emit) begin
      o_r <= ew;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && out_stall |=> o_vld_r)
    else $error("output word lost");
  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> in_stall)
    else $error("input taken during drain read");
  a_drain_phase: assert property (@(posedge clk) disable iff (!rst_n)
    drain |-> ph_r == PH_COPY)
    else $error("drain outside copy");
  a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
    drain |=> ##1 o_vld_r)
    else $error("drained byte missing");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams one long LZ4 frame through the decompressor: header with content
// size, dictionary id and block checksums, stored and compressed blocks, match
// copies drained by ticks, bad offsets, refused bytes, and the end mark.
// A scoreboard predicts every result word and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lz4fd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STREAM_ITEMS = 1400;

  class lz4_scoreboard;
    phase_t      ph;
    logic [3:0]  fcnt;
    logic [3:0]  hskip;
    logic [31:0] acc;
    logic [30:0] blk_left;
    bit          cks_on;
    logic [3:0]  nib;
    logic [31:0] lit_left;
    logic [15:0] ofs;
    logic [31:0] match_left;
    logic [31:0] produced;
    logic [15:0] wpos;
    logic [7:0]  hist [65536];
    out_word_t   expected_q [$];
    int          errors;
    int          n_in;
    int          n_out;

    function new();
      ph = PH_MAGIC;
      fcnt = '0; hskip = '0; acc = '0; blk_left = '0; cks_on = 1'b0; nib = '0;
      lit_left = '0; ofs = '0; match_left = '0; produced = '0; wpos = '0;
      errors = 0; n_in = 0; n_out = 0;
      foreach (hist[i]) hist[i] = 8'h00;
    endfunction

    function logic [31:0] add_sat(logic [31:0] a, logic [7:0] b);
      logic [32:0] s;
      s = {1'b0, a} + 33'(b);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void push_word(logic [7:0] b, kind_t k);
      out_word_t w;
      w.out_byte = b;
      w.kind = k;
      w.total_length = produced;
      w.copy_pending = (match_left != 0);
      expected_q.push_back(w);
    endfunction

    function void put_byte(logic [7:0] b);
      hist[wpos] = b;
      wpos++;
      produced = add_sat(produced, 8'd1);
      push_word(b, KIND_DATA);
    endfunction

    function void begin_size();
      ph = PH_BSIZE;
      fcnt = '0;
      acc = '0;
    endfunction

    function void end_block();
      if (cks_on) begin
        ph = PH_CKSUM;
        fcnt = '0;
      end else begin
        begin_size();
      end
    endfunction

    function void end_seq();
      if (blk_left == 0) end_block();
      else ph = PH_TOKEN;
    endfunction

    function void after_lit();
      if (blk_left == 0) begin
        end_block();
      end else begin
        ph = PH_OFFSET;
        fcnt = '0;
        ofs = '0;
      end
    endfunction

    function void lit_known();
      if (lit_left != 0) ph = PH_LITERAL;
      else after_lit();
    endfunction

    function void start_match();
      if (ofs == 0 || ofs > produced) begin
        match_left = '0;
        end_seq();
        push_word(8'h00, KIND_BAD_OFS);
      end else begin
        ph = PH_COPY;
      end
    endfunction

    function void note_input(in_word_t w);
      logic [7:0]  b;
      logic [15:0] idx;
      b = w.in_byte;
      n_in++;
      if (w.op) begin
        if (ph != PH_COPY || match_left == 0) return;
        idx = wpos - ofs;
        match_left--;
        if (match_left == 0) end_seq();
        put_byte(hist[idx]);
        return;
      end
      if (ph == PH_COPY) begin
        push_word(8'h00, KIND_REFUSED);
        return;
      end
      if (ph == PH_MATCHEXT) begin
        if (blk_left != 0) blk_left--;
        match_left = add_sat(match_left, b);
        if (b != 8'hFF) start_match();
        return;
      end
      if (ph > PH_CKSUM) return;
      case (ph)
        PH_MAGIC: begin
          if (b != FRAME_MAGIC[8*fcnt[1:0] +: 8]) begin
            ph = PH_DEAD;
            push_word(8'h00, KIND_BAD_MAG);
          end else begin
            fcnt++;
            if (fcnt >= 4) begin
              fcnt = '0;
              ph = PH_FLG;
            end
          end
          return;
        end
        PH_FLG: begin
          cks_on = b[4];
          hskip = 4'd2 + (b[3] ? 4'd8 : 4'd0) + (b[0] ? 4'd4 : 4'd0);
          ph = PH_HDR;
          return;
        end
        PH_HDR: begin
          if (hskip != 0) hskip--;
          if (hskip == 0) begin_size();
          return;
        end
        PH_BSIZE: begin
          acc[8*fcnt[1:0] +: 8] = acc[8*fcnt[1:0] +: 8] | b;
          fcnt++;
          if (fcnt < 4) return;
          fcnt = '0;
          if (acc == 0) begin
            ph = PH_DONE;
            push_word(8'h00, KIND_END);
            return;
          end
          blk_left = acc[30:0];
          if (acc[31]) begin
            if (blk_left == 0) end_block();
            else ph = PH_STORED;
          end else begin
            ph = PH_TOKEN;
          end
          return;
        end
        PH_STORED: begin
          if (blk_left != 0) blk_left--;
          if (blk_left == 0) end_block();
          put_byte(b);
          return;
        end
        PH_CKSUM: begin
          fcnt++;
          if (fcnt >= 4) begin_size();
          return;
        end
        default: ;
      endcase
      // compressed block bytes
      if (blk_left != 0) blk_left--;
      case (ph)
        PH_TOKEN: begin
          nib = b[3:0];
          lit_left = 32'(b[7:4]);
          if (lit_left == 15) ph = PH_LITEXT;
          else lit_known();
        end
        PH_LITEXT: begin
          lit_left = add_sat(lit_left, b);
          if (b != 8'hFF) lit_known();
        end
        PH_LITERAL: begin
          lit_left--;
          if (lit_left == 0) after_lit();
          put_byte(b);
        end
        PH_OFFSET: begin
          ofs[8*fcnt[0] +: 8] = ofs[8*fcnt[0] +: 8] | b;
          fcnt++;
          if (fcnt >= 2) begin
            fcnt = '0;
            match_left = 32'(nib) + 32'd4;
            if (match_left == 19) ph = PH_MATCHEXT;
            else start_match();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_word_t a);
      out_word_t e;
      n_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, a);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.out_byte !== e.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, a.out_byte);
        errors++;
      end
      if (a.kind !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, a.kind);
        errors++;
      end
      if (a.total_length !== e.total_length) begin
        $display("%0t: total_length expected %0d actual %0d", $time,
                 e.total_length, a.total_length);
        errors++;
      end
      if (a.copy_pending !== e.copy_pending) begin
        $display("%0t: copy_pending expected %b actual %b", $time,
                 e.copy_pending, a.copy_pending);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_word_t out_data;

  lz4_scoreboard sb = new();
  in_word_t      stream_q [$];
  in_word_t      body_q [$];
  int            body_cnt;
  int            gen_out;
  int            cycles;
  bit            running = 0;

  lz4_frame_decompressor uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // check the result first: it belongs to an earlier word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall: segments of no stall, random stall, and long stalls
  int stall_mode = 0;
  int seg_left = 0;
  int stall_run = 0;
  always @(negedge clk) begin
    if (seg_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      seg_left <= $urandom_range(20, 120);
    end else begin
      seg_left <= seg_left - 1;
    end
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if (stall_mode == 1) begin
      out_stall <= ($urandom_range(0, 99) < 40);
    end else if (stall_mode == 2 && $urandom_range(0, 19) == 0) begin
      stall_run <= $urandom_range(3, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function void put(logic op, logic [7:0] b, bit counted);
    in_word_t w;
    w.op = op;
    w.in_byte = b;
    body_q.push_back(w);
    if (counted) body_cnt++;
  endfunction

  function void put_stream(logic [7:0] b);
    in_word_t w;
    w.op = 1'b0;
    w.in_byte = b;
    stream_q.push_back(w);
  endfunction

  function void put_len(int r);
    while (r >= 255) begin
      put(1'b0, 8'hFF, 1'b1);
      r -= 255;
    end
    put(1'b0, r[7:0], 1'b1);
  endfunction

  // one sequence; a valid match is followed by enough drain ticks
  function void gen_seq(int nlit, bit last, int ofs, int nb, int ext, bit refuse);
    int ml;
    put(1'b0, {(nlit >= 15) ? 4'hF : nlit[3:0], nb[3:0]}, 1'b1);
    if (nlit >= 15) put_len(nlit - 15);
    repeat (nlit) put(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    gen_out += nlit;
    if (last) return;
    put(1'b0, ofs[7:0], 1'b1);
    put(1'b0, ofs[15:8], 1'b1);
    if (nb == 15) put_len(ext);
    ml = nb + 4 + ((nb == 15) ? ext : 0);
    if (ofs != 0 && ofs <= gen_out) begin
      for (int i = 0; i < ml; i++) begin
        if (refuse && i == ml / 2) put(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        put(1'b1, 8'($urandom_range(0, 255)), 1'b0);
      end
      gen_out += ml;
    end
    if ($urandom_range(0, 9) == 0) put(1'b1, 8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function void rand_seq(bit last);
    int nlit, ofs, r, top;
    r = $urandom_range(0, 99);
    if (r < 3) nlit = 270 + $urandom_range(0, 40);
    else if (r < 20) nlit = $urandom_range(15, 40);
    else nlit = $urandom_range(0, 14);
    if (gen_out + nlit > 0 && $urandom_range(0, 9) != 0) begin
      top = (gen_out + nlit > 65535) ? 65535 : gen_out + nlit;
      if ($urandom_range(0, 1)) ofs = $urandom_range(1, (top < 16) ? top : 16);
      else ofs = $urandom_range(1, top);
    end else if ($urandom_range(0, 1) || gen_out + nlit >= 65535) begin
      ofs = 0;
    end else begin
      ofs = $urandom_range(gen_out + nlit + 1, 65535);
    end
    gen_seq(nlit, last, ofs, $urandom_range(0, 15),
            ($urandom_range(0, 7) == 0) ? 255 + $urandom_range(0, 10) : $urandom_range(0, 20),
            $urandom_range(0, 14) == 0);
  endfunction

  // size word, body, then the block checksum (always enabled by the header)
  function void emit_block(bit stored, int sz);
    logic [31:0] s;
    s = {stored, sz[30:0]};
    for (int i = 0; i < 4; i++) put_stream(s[8*i +: 8]);
    foreach (body_q[i]) stream_q.push_back(body_q[i]);
    repeat (4) put_stream(8'($urandom_range(0, 255)));
    body_q.delete();
    body_cnt = 0;
    if ($urandom_range(0, 5) == 0)
      stream_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function void stored_block(int n);
    repeat (n) put(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    gen_out += n;
    emit_block(1'b1, n);
  endfunction

  function void build_stream();
    // magic, then FLG with checksum, content size and dictionary id bits set
    for (int i = 0; i < 4; i++) put_stream(FRAME_MAGIC[8*i +: 8]);
    put_stream(8'h19);
    repeat (14) put_stream(8'($urandom_range(0, 255)));
    stream_q.push_back({1'b1, 8'hFF});
    put(1'b0, 8'h00, 1'b1);
    put(1'b0, 8'hFF, 1'b1);
    put(1'b0, 8'h5A, 1'b1);
    gen_out += 3;
    emit_block(1'b1, 3);
    emit_block(1'b1, 0);
    // zero offset, then a copy with extended length and a refused byte
    gen_seq(2, 1'b0, 0, 0, 0, 1'b0);
    gen_seq(1, 1'b0, 2, 15, 3, 1'b1);
    gen_seq(0, 1'b1, 0, 0, 0, 1'b0);
    emit_block(1'b0, body_cnt);
    // block size smaller than its one sequence
    gen_seq(3, 1'b1, 0, 0, 0, 1'b0);
    emit_block(1'b0, 1);
    while (stream_q.size() < STREAM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        stored_block($urandom_range(1, 12));
      end else begin
        repeat ($urandom_range(0, 3)) rand_seq(1'b0);
        rand_seq(1'b1);
        emit_block(1'b0, body_cnt);
      end
    end
    repeat (4) put_stream(8'h00);
    repeat (3) put_stream(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_stream();
    int burst;
    int half;
    burst = 0;
    half = stream_q.size() / 2;
    for (int i = 0; i < stream_q.size(); i++) begin
      if (i == half) begin
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
      end
      burst--;
      in_valid <= 1'b1;
      in_data <= stream_q[i];
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    build_stream();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_stream();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, sb.expected_q.size());
      sb.errors++;
    end
    $display("run covered %0d input words and %0d result words in one frame",
             sb.n_in, sb.n_out);
    $display("stored, compressed and short blocks, copies, bad offsets, refusals");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
